// ===== rtl/rtte_pkg.sv =====
// ----------------------------------------------------------------------------
// RTT timeout estimator package
// Shared constants, event codes and register indexes.
// ----------------------------------------------------------------------------
package rtte_pkg;

   localparam int CFG_BITS      = 32;
   localparam int OUT_BITS      = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int FRAC_BITS     = 3;
   localparam int DEF_TIME_BITS = 32;

   localparam logic [CFG_BITS-1:0] DEF_INIT_TIMEOUT   = 32'd1000000;
   localparam logic [CFG_BITS-1:0] DEF_INIT_ESTIMATE  = 32'd1000000;
   localparam logic [CFG_BITS-1:0] DEF_INIT_DEVIATION = 32'd500000;
   localparam logic [CFG_BITS-1:0] DEF_TIMEOUT_CAP    = 32'd30000000;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_INIT_TIMEOUT   = 4'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_INIT_ESTIMATE  = 4'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_INIT_DEVIATION = 4'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TIMEOUT_CAP    = 4'd3;

   typedef enum logic [1:0] {
      OP_ACK     = 2'd0,
      OP_TIMEOUT = 2'd1,
      OP_NACK    = 2'd2
   } opcode_type;

endpackage

// ===== rtl/rtte_calc.sv =====
// ----------------------------------------------------------------------------
// RTT timeout estimator update
// Next smoothed RTT, deviation, timeout and backoff flag for one event word.
// ----------------------------------------------------------------------------
module rtte_calc #(
   parameter int TIME_BITS = rtte_pkg::DEF_TIME_BITS
) (
   input  logic [1:0]                               op,
   input  logic [rtte_pkg::CFG_BITS-1:0]            rtt_sample,
   input  logic [TIME_BITS+rtte_pkg::FRAC_BITS-1:0] est,
   input  logic [TIME_BITS+rtte_pkg::FRAC_BITS-1:0] dev,
   input  logic [TIME_BITS-1:0]                     tmo,
   input  logic                                     backoff,
   input  logic [TIME_BITS-1:0]                     cap,
   output logic [TIME_BITS+rtte_pkg::FRAC_BITS-1:0] est_next,
   output logic [TIME_BITS+rtte_pkg::FRAC_BITS-1:0] dev_next,
   output logic [TIME_BITS-1:0]                     tmo_next,
   output logic                                     backoff_next
);
   import rtte_pkg::*;

   localparam int EW = TIME_BITS + FRAC_BITS;

   function automatic logic [TIME_BITS-1:0] limit_fn(input logic [TIME_BITS+2:0] t,
                                                     input logic [TIME_BITS-1:0] c);
      logic [TIME_BITS-1:0] r;
      if (t > {3'b000, c}) begin
         r = c;
      end else begin
         r = t[TIME_BITS-1:0];
      end
      if (r == '0) begin
         r = TIME_BITS'(1);
      end
      return r;
   endfunction

   logic [TIME_BITS-1:0] sample_t;
   logic [EW-1:0]        sample_fx;
   logic [EW+2:0]        est_acc;
   logic [EW-1:0]        est_new;
   logic [EW-1:0]        diff;
   logic [EW+1:0]        dev_acc;
   logic [EW-1:0]        dev_new;
   logic [EW-1:0]        est_sel;
   logic [EW-1:0]        dev_sel;
   logic [EW+2:0]        sum;
   logic [TIME_BITS-1:0] tmo_ack;
   logic [TIME_BITS-1:0] tmo_dbl;

   assign sample_t  = TIME_BITS'(rtt_sample);
   assign sample_fx = {sample_t, {FRAC_BITS{1'b0}}};

   // est + (sample - est) / 8, as (7 * est + sample) >> 3
   assign est_acc = ({3'b000, est} << 3) - {3'b000, est} + {3'b000, sample_fx};
   assign est_new = est_acc[EW+2:3];
   assign diff    = (sample_fx > est_new) ? (sample_fx - est_new) : (est_new - sample_fx);
   assign dev_acc = ({2'b00, dev} << 1) + {2'b00, dev} + {2'b00, diff};
   assign dev_new = dev_acc[EW+1:2];

   // Karn: no sampling while backed off
   assign est_sel = backoff ? est : est_new;
   assign dev_sel = backoff ? dev : dev_new;

   assign sum     = {3'b000, est_sel} + {1'b0, dev_sel, 2'b00};
   assign tmo_ack = limit_fn(sum[EW+2:3], cap);
   assign tmo_dbl = limit_fn({2'b00, tmo, 1'b0}, cap);

   always_comb begin
      est_next     = est;
      dev_next     = dev;
      tmo_next     = tmo;
      backoff_next = backoff;
      unique case (op)
         OP_ACK: begin
            est_next     = est_sel;
            dev_next     = dev_sel;
            tmo_next     = tmo_ack;
            backoff_next = 1'b0;
         end
         OP_TIMEOUT: begin
            tmo_next     = tmo_dbl;
            backoff_next = 1'b1;
         end
         OP_NACK: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/rtt_timeout_estimator_top.sv =====
// ----------------------------------------------------------------------------
// RTT timeout estimator
// Smoothed RTT and deviation tracking with exponential backoff on timeouts.
// ----------------------------------------------------------------------------
// One event word is taken per clock cycle and each gives exactly one result
// word in the cycle after acceptance. The estimator state updates in a single
// pass from the state registers into the result register, so events can
// follow back to back; the request side stalls only when the result register
// is full and not being drained. Configuration writes are held off while a
// request word is offered: writing an initial value also loads the matching
// state, and a cap write applies from the next computed timeout onward.
// ----------------------------------------------------------------------------
module rtt_timeout_estimator_top #(
   parameter int TIME_BITS = rtte_pkg::DEF_TIME_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_opcode,
   input  logic [rtte_pkg::CFG_BITS-1:0]      req_rtt_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rtte_pkg::OUT_BITS-1:0]      rsp_timeout_value,
   output logic                               rsp_in_backoff,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rtte_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [rtte_pkg::CFG_BITS-1:0]      csr_wdata
);
   import rtte_pkg::*;

   localparam int EW = TIME_BITS + FRAC_BITS;

   function automatic logic [TIME_BITS-1:0] load_tmo_fn(input logic [CFG_BITS-1:0] v);
      logic [TIME_BITS-1:0] t;
      t = TIME_BITS'(v);
      if (t == '0) begin
         t = TIME_BITS'(1);
      end
      return t;
   endfunction

   logic [EW-1:0]        est_ff;
   logic [EW-1:0]        dev_ff;
   logic [TIME_BITS-1:0] tmo_ff;
   logic                 backoff_ff;
   logic [TIME_BITS-1:0] cap_ff;
   logic                 rsp_valid_ff;
   logic [OUT_BITS-1:0]  rsp_timeout_ff;
   logic                 rsp_backoff_ff;

   logic [EW-1:0]        est_in;
   logic [EW-1:0]        dev_in;
   logic [TIME_BITS-1:0] tmo_in;
   logic                 backoff_in;
   logic                 req_accept;
   logic                 csr_write;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = !req_valid;
   assign csr_write  = csr_valid && csr_ready;

   rtte_calc #(
      .TIME_BITS(TIME_BITS)
   ) u_calc (
      .op           (req_opcode),
      .rtt_sample   (req_rtt_sample),
      .est          (est_ff),
      .dev          (dev_ff),
      .tmo          (tmo_ff),
      .backoff      (backoff_ff),
      .cap          (cap_ff),
      .est_next     (est_in),
      .dev_next     (dev_in),
      .tmo_next     (tmo_in),
      .backoff_next (backoff_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff       <= {TIME_BITS'(DEF_INIT_ESTIMATE), {FRAC_BITS{1'b0}}};
         dev_ff       <= {TIME_BITS'(DEF_INIT_DEVIATION), {FRAC_BITS{1'b0}}};
         tmo_ff       <= load_tmo_fn(DEF_INIT_TIMEOUT);
         backoff_ff   <= 1'b0;
         cap_ff       <= TIME_BITS'(DEF_TIMEOUT_CAP);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            priority if (csr_addr == CSR_INIT_TIMEOUT) begin
               tmo_ff <= load_tmo_fn(csr_wdata);
            end else if (csr_addr == CSR_INIT_ESTIMATE) begin
               est_ff <= {TIME_BITS'(csr_wdata), {FRAC_BITS{1'b0}}};
            end else if (csr_addr == CSR_INIT_DEVIATION) begin
               dev_ff <= {TIME_BITS'(csr_wdata), {FRAC_BITS{1'b0}}};
            end else if (csr_addr == CSR_TIMEOUT_CAP) begin
               cap_ff <= TIME_BITS'(csr_wdata);
            end else begin
            end
         end else if (req_accept) begin
            est_ff     <= est_in;
            dev_ff     <= dev_in;
            tmo_ff     <= tmo_in;
            backoff_ff <= backoff_in;
         end
      end
   end

   // result payload, loaded on accept only
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_timeout_ff <= OUT_BITS'(tmo_in);
         rsp_backoff_ff <= backoff_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_timeout_value = rsp_timeout_ff;
   assign rsp_in_backoff    = rsp_backoff_ff;

   a_tmo_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_timeout_ff != '0)
      else $error("result timeout is zero");

   a_timeout_sets_backoff: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_opcode == OP_TIMEOUT |=> rsp_backoff_ff && backoff_ff)
      else $error("timeout event did not enter backoff");

   a_nack_holds: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_opcode == OP_NACK && !csr_write |=>
         tmo_ff == $past(tmo_ff) && backoff_ff == $past(backoff_ff)
         && rsp_timeout_ff == OUT_BITS'($past(tmo_ff)))
      else $error("nack changed estimator state");

endmodule
